### design/ipv4rx_pkg.sv
// ----------------------------------------------------------------------------
// ipv4rx_pkg
// Shared types and constants for the IPv4 receive header check.
// ----------------------------------------------------------------------------
package ipv4rx_pkg;

   localparam logic [15:0] HdrBytes = 16'd20;
   localparam logic [3:0]  IpVersion4 = 4'd4;

   localparam logic [2:0] StAccept   = 3'd0;
   localparam logic [2:0] StShort    = 3'd1;
   localparam logic [2:0] StVersion  = 3'd2;
   localparam logic [2:0] StLength   = 3'd3;
   localparam logic [2:0] StChecksum = 3'd4;
   localparam logic [2:0] StDest     = 3'd5;

   // one byte moving from the input register into the capture logic
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } step_type;

   // per-packet header state as it stands after the current byte
   typedef struct packed {
      logic [15:0] count;
      logic [15:0] sum;
      logic [3:0]  version;
      logic [15:0] length;
      logic [15:0] checksum;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] dest;
   } hdr_type;

endpackage

### design/ipv4rx_hdr_capture.sv
// ----------------------------------------------------------------------------
// ipv4rx_hdr_capture
// Counts packet bytes, captures the fixed header fields and keeps the
// one's-complement header sum. Presents the state as it stands after the
// current byte; clears after the last byte of a packet.
// ----------------------------------------------------------------------------
module ipv4rx_hdr_capture (
   input  logic               clock,
   input  logic               reset,
   input  ipv4rx_pkg::step_type step,
   output ipv4rx_pkg::hdr_type  hdr
);
   import ipv4rx_pkg::*;

   localparam logic [4:0] PosVersion = 5'd0;
   localparam logic [4:0] PosLenHi   = 5'd2;
   localparam logic [4:0] PosLenLo   = 5'd3;
   localparam logic [4:0] PosProto   = 5'd9;
   localparam logic [4:0] PosCsumHi  = 5'd10;
   localparam logic [4:0] PosCsumLo  = 5'd11;
   localparam logic [4:0] PosSrc     = 5'd12;
   localparam logic [4:0] PosSrcEnd  = 5'd15;
   localparam logic [4:0] PosDst     = 5'd16;
   localparam logic [4:0] PosDstEnd  = 5'd19;

   hdr_type    hdr_ff;
   hdr_type    hdr_in;
   logic [7:0] high_ff;
   logic [7:0] high_in;
   logic [4:0] pos;
   logic [15:0] word;

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   assign pos = hdr_ff.count[4:0];

   always_comb begin
      hdr_in  = hdr_ff;
      high_in = high_ff;
      word    = {high_ff, step.data};
      if (hdr_ff.count != 16'hFFFF) begin
         hdr_in.count = hdr_ff.count + 16'd1;
      end
      if (hdr_ff.count < HdrBytes) begin
         case (pos)
            PosVersion: hdr_in.version        = step.data[7:4];
            PosLenHi:   hdr_in.length[15:8]   = step.data;
            PosLenLo:   hdr_in.length[7:0]    = step.data;
            PosProto:   hdr_in.protocol       = step.data;
            PosCsumHi:  hdr_in.checksum[15:8] = step.data;
            PosCsumLo:  hdr_in.checksum[7:0]  = step.data;
            default: ;
         endcase
         if (pos inside {[PosSrc:PosSrcEnd]}) begin
            case (pos[1:0])
               2'd0:    hdr_in.source[31:24] = step.data;
               2'd1:    hdr_in.source[23:16] = step.data;
               2'd2:    hdr_in.source[15:8]  = step.data;
               default: hdr_in.source[7:0]   = step.data;
            endcase
         end
         if (pos inside {[PosDst:PosDstEnd]}) begin
            case (pos[1:0])
               2'd0:    hdr_in.dest[31:24] = step.data;
               2'd1:    hdr_in.dest[23:16] = step.data;
               2'd2:    hdr_in.dest[15:8]  = step.data;
               default: hdr_in.dest[7:0]   = step.data;
            endcase
         end
         if (!pos[0]) begin
            high_in = step.data;
         end else begin
            // checksum word counts as zero
            if (pos == PosCsumLo) begin
               word = 16'd0;
            end
            hdr_in.sum = ones_add(hdr_ff.sum, word);
         end
      end
   end

   assign hdr = hdr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= '0;
         high_ff <= '0;
      end else if (step.valid) begin
         if (step.last) begin
            hdr_ff  <= '0;
            high_ff <= '0;
         end else begin
            hdr_ff  <= hdr_in;
            high_ff <= high_in;
         end
      end
   end

endmodule

### design/ipv4_rx_header_check.sv
// ----------------------------------------------------------------------------
// ipv4_rx_header_check
// A verdict appears on rsp_ once the last byte has passed from the input
// register to the result register.
// Throughput: one byte per cycle; a last byte waits only while the previous
// verdict is still held by rsp_stall. Synchronous reset clears the local
// address, the packet state and both valid flags.
// ----------------------------------------------------------------------------
module ipv4_rx_header_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_local_ip,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_protocol,
   output logic [31:0] rsp_src_ip,
   output logic [15:0] rsp_payload_len,
   output logic [15:0] rsp_received_len
);
   import ipv4rx_pkg::*;

   logic [31:0] local_ip_ff;
   logic        in_valid_ff;
   logic        in_last_ff;
   logic [7:0]  in_data_ff;
   logic        advance;
   step_type    step;
   hdr_type     hdr;
   logic [2:0]  status_in;
   logic [15:0] payload_in;

   logic        rsp_valid_ff;
   logic [2:0]  status_ff;
   logic [7:0]  protocol_ff;
   logic [31:0] src_ff;
   logic [15:0] payload_ff;
   logic [15:0] received_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         local_ip_ff <= csr_local_ip;
      end
   end

   // a last byte moves on only when the result register is free or emptying
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
   end

   assign step.valid = advance;
   assign step.last  = in_last_ff;
   assign step.data  = in_data_ff;

   ipv4rx_hdr_capture u_capture (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .hdr   (hdr)
   );

   always_comb begin
      payload_in = 16'd0;
      if (hdr.count < HdrBytes) begin
         status_in = StShort;
      end else if (hdr.version != IpVersion4) begin
         status_in = StVersion;
      end else if (hdr.length > hdr.count || hdr.length < HdrBytes) begin
         status_in = StLength;
      end else if (hdr.checksum != ~hdr.sum) begin
         status_in = StChecksum;
      end else if (hdr.dest != local_ip_ff) begin
         status_in = StDest;
      end else begin
         status_in  = StAccept;
         payload_in = hdr.length - HdrBytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         status_ff   <= status_in;
         protocol_ff <= hdr.protocol;
         src_ff      <= hdr.source;
         payload_ff  <= payload_in;
         received_ff <= hdr.count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_protocol     = protocol_ff;
   assign rsp_src_ip       = src_ff;
   assign rsp_payload_len  = payload_ff;
   assign rsp_received_len = received_ff;

`ifndef SYNTH
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a held verdict");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= StDest))
      else $error("verdict code out of range");

   a_short_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == StShort) == (rsp_received_len < HdrBytes)))
      else $error("short verdict disagrees with byte count");

   a_payload_fits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == StAccept) |->
         ({1'b0, rsp_payload_len} + {1'b0, HdrBytes} <= {1'b0, rsp_received_len}))
      else $error("accepted payload longer than received bytes");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != StAccept) |-> (rsp_payload_len == 16'd0))
      else $error("payload length reported on a rejected packet");
`endif

endmodule
